@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the receiver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define FPRX_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fprx assertion failed");
// condition in one cycle implies a condition in the next
`define FPRX_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("fprx assertion failed");
`else
`define FPRX_ASSERT(lbl, prop)
`define FPRX_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

@@ rtl/core/fprx_pkg.sv @@
// shared types, constants and crc function for the frame receiver
package fprx_pkg;

    localparam int PL_MAX    = 256;
    localparam int PL_AW     = $clog2(PL_MAX);
    localparam int MEM_DEPTH = 2 * PL_MAX;
    localparam int MEM_AW    = PL_AW + 1;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CFG_FIRST_HEADER  = 2'd0,
        CFG_SECOND_HEADER = 2'd1,
        CFG_TAIL_MARKER   = 2'd2,
        CFG_LENGTH_LIMIT  = 2'd3
    } cfg_idx_t;

    typedef enum logic [7:0] {
        PH_HDR1 = 8'b0000_0001,
        PH_HDR2 = 8'b0000_0010,
        PH_CMD  = 8'b0000_0100,
        PH_LENH = 8'b0000_1000,
        PH_LENL = 8'b0001_0000,
        PH_DATA = 8'b0010_0000,
        PH_CRC  = 8'b0100_0000,
        PH_TAIL = 8'b1000_0000
    } phase_t;

    // payload memory write request
    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    // delivered frame view
    typedef struct packed {
        logic       bank;
        logic [7:0] cmd;
        logic [8:0] length;
    } dlv_t;

    // per-word result fields other than read data
    typedef struct packed {
        logic       packet_valid;
        logic [7:0] cmd;
        logic [8:0] length;
    } res_t;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/core/fprx_parser.sv @@
// frame parser: header search, length check, crc and delivery
module fprx_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                action,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data,
    output fprx_pkg::mem_wr_t   wr,
    output fprx_pkg::dlv_t      dlv,
    output fprx_pkg::res_t      res
);
    import fprx_pkg::*;

    logic [7:0]  hdr1_reg, hdr2_reg, tail_reg;
    logic [8:0]  limit_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  lenh_reg, lenh_next;
    logic [8:0]  len_reg, len_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [1:0]  crc_cnt_reg, crc_cnt_next;
    logic [31:0] rx_crc_reg, rx_crc_next;
    logic [31:0] run_crc_reg, run_crc_next;
    dlv_t        dlv_reg, dlv_next;
    logic        deliver;
    logic [15:0] len16, lim16;
    logic [8:0]  cnt_inc;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr1_reg  <= 8'd170;
            hdr2_reg  <= 8'd85;
            tail_reg  <= 8'd187;
            limit_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FIRST_HEADER:  hdr1_reg  <= cfg_data[7:0];
                CFG_SECOND_HEADER: hdr2_reg  <= cfg_data[7:0];
                CFG_TAIL_MARKER:   tail_reg  <= cfg_data[7:0];
                CFG_LENGTH_LIMIT:  limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign len16   = {lenh_reg, rx_byte};
    assign lim16   = (16'(limit_reg) > 16'(PL_MAX)) ? 16'(PL_MAX) : 16'(limit_reg);
    assign cnt_inc = cnt_reg + 9'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        lenh_next    = lenh_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        crc_cnt_next = crc_cnt_reg;
        rx_crc_next  = rx_crc_reg;
        run_crc_next = run_crc_reg;
        dlv_next     = dlv_reg;
        deliver      = 1'b0;
        wr.en        = 1'b0;
        wr.addr      = {~dlv_reg.bank, PL_AW'(cnt_reg)};
        wr.data      = rx_byte;
        if (accept && !action)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    if (rx_byte == hdr1_reg)
                        phase_next = PH_HDR2;
                end
                PH_HDR2: phase_next = (rx_byte == hdr2_reg) ? PH_CMD : PH_HDR1;
                PH_CMD:
                begin
                    cmd_next   = rx_byte;
                    phase_next = PH_LENH;
                end
                PH_LENH:
                begin
                    lenh_next  = rx_byte;
                    phase_next = PH_LENL;
                end
                PH_LENL:
                begin
                    if (len16 > lim16)
                        phase_next = PH_HDR1;
                    else
                    begin
                        len_next     = len16[8:0];
                        cnt_next     = 9'd0;
                        crc_cnt_next = 2'd0;
                        run_crc_next = CRC_INIT;
                        phase_next   = (len16 != 16'd0) ? PH_DATA : PH_CRC;
                    end
                end
                PH_DATA:
                begin
                    wr.en        = (16'(cnt_reg) < 16'(PL_MAX));
                    run_crc_next = crc_byte(run_crc_reg, rx_byte);
                    cnt_next     = cnt_inc;
                    if (cnt_inc >= len_reg)
                    begin
                        crc_cnt_next = 2'd0;
                        phase_next   = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    rx_crc_next = {rx_crc_reg[23:0], rx_byte};
                    if (crc_cnt_reg == 2'd3)
                    begin
                        crc_cnt_next = 2'd0;
                        phase_next   = PH_TAIL;
                    end
                    else
                        crc_cnt_next = crc_cnt_reg + 2'd1;
                end
                PH_TAIL:
                begin
                    phase_next = PH_HDR1;
                    if (rx_byte == tail_reg && ~run_crc_reg == rx_crc_reg)
                    begin
                        deliver         = 1'b1;
                        dlv_next.bank   = ~dlv_reg.bank;
                        dlv_next.cmd    = cmd_reg;
                        dlv_next.length = len_reg;
                    end
                end
                default: phase_next = PH_HDR1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR1;
            cmd_reg     <= 8'd0;
            lenh_reg    <= 8'd0;
            len_reg     <= 9'd0;
            cnt_reg     <= 9'd0;
            crc_cnt_reg <= 2'd0;
            rx_crc_reg  <= 32'd0;
            run_crc_reg <= CRC_INIT;
            dlv_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            lenh_reg    <= lenh_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            crc_cnt_reg <= crc_cnt_next;
            rx_crc_reg  <= rx_crc_next;
            run_crc_reg <= run_crc_next;
            dlv_reg     <= dlv_next;
        end
    end

    assign dlv              = dlv_reg;
    assign res.packet_valid = deliver;
    assign res.cmd          = dlv_next.cmd;
    assign res.length       = dlv_next.length;

`include "assert_macros.svh"
    `FPRX_ASSERT_NEXT(a_bank_swaps, deliver, dlv_reg.bank != $past(dlv_reg.bank))
    `FPRX_ASSERT(a_crc_cnt_phase, (crc_cnt_reg == 2'd0) || (phase_reg == PH_CRC))

endmodule

@@ rtl/core/fprx_store.sv @@
// two-bank payload memory with registered read port
module fprx_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              action,
    input  logic [7:0]        read_index,
    input  fprx_pkg::dlv_t    dlv,
    input  fprx_pkg::mem_wr_t wr,
    output logic [7:0]        read_data
);
    import fprx_pkg::*;

    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        q_reg;
    logic              zero_reg;
    logic              rd_en;
    logic              in_range;
    logic [MEM_AW-1:0] rd_addr;

    assign rd_en    = accept && action;
    assign in_range = (9'(read_index) < dlv.length) && (16'(read_index) < 16'(PL_MAX));
    assign rd_addr  = {dlv.bank, PL_AW'(read_index)};

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        if (rd_en)
            q_reg <= mem[rd_addr];
    end

    // zero flag held with the read word until the next accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zero_reg <= 1'b1;
        else if (accept)
            zero_reg <= !(action && in_range);
    end

    assign read_data = zero_reg ? 8'd0 : q_reg;

`include "assert_macros.svh"
    `FPRX_ASSERT(a_no_rw_same_cycle, !(wr.en && rd_en))

endmodule

@@ rtl/core/framed_packet_receiver_crc32_top.sv @@
// top level of the framed packet receiver with crc-32
//
// takes one word per cycle while in_stall is low: a received byte (action 0) or a read of the last
// delivered payload (action 1), and returns one result word per input word.
// frames are first header, second header, command, 16-bit big-endian length,
// payload, big-endian reflected crc-32 over the payload, tail byte. a good
// frame raises packet_valid on the word of its tail byte and swaps the two
// payload banks, so reads see the delivered payload while the next frame
// fills the other bank. throughput is one word per cycle while not stalled; each result passes
// through the synchronous payload memory read and then the output register.
// a skid stage lets a new word be taken while a result waits at the output.
// payload memory holds 2 x 256 bytes and needs no clearing after reset.
module framed_packet_receiver_crc32_top (
    input  logic       clk,
    input  logic       rst_n,
    // input word channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] rx_byte,
    input  logic [7:0] read_index,
    // configuration write port
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    // result word channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       packet_valid,
    output logic [7:0] cmd_out,
    output logic [8:0] length_out,
    output logic [7:0] read_data
);
    import fprx_pkg::*;

    logic       accept;
    mem_wr_t    wr;
    dlv_t       dlv;
    res_t       res;
    logic [7:0] mem_data;

    // stage 1: memory read in flight, result fields alongside
    logic       s1_valid_reg;
    res_t       s1_res_reg;
    logic       s1_adv;

    // stage 2: output register
    logic       out_valid_reg;
    res_t       out_res_reg;
    logic [7:0] out_data_reg;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    fprx_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr        (wr),
        .dlv       (dlv),
        .res       (res)
    );

    // read data stays in the memory output register until the next accept,
    // which only happens once stage 1 has moved on
    fprx_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (action),
        .read_index (read_index),
        .dlv        (dlv),
        .wr         (wr),
        .read_data  (mem_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept || (s1_valid_reg && !s1_adv);
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_res_reg <= res;
        if (s1_adv)
        begin
            out_res_reg  <= s1_res_reg;
            out_data_reg <= mem_data;
        end
    end

    assign out_valid    = out_valid_reg;
    assign packet_valid = out_res_reg.packet_valid;
    assign cmd_out      = out_res_reg.cmd;
    assign length_out   = out_res_reg.length;
    assign read_data    = out_data_reg;

`include "assert_macros.svh"
    `FPRX_ASSERT(a_full_stalls_input, !(s1_valid_reg && out_valid_reg && out_stall) || in_stall)
    `FPRX_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_reg)
    `FPRX_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_reg)

endmodule

@@ verif/tb_framed_packet_receiver_crc32_top.sv @@
// self-checking testbench for the framed packet receiver with crc-32
module tb_framed_packet_receiver_crc32_top;

    localparam int PAYLOAD_MAX  = fprx_pkg::PL_MAX;
    localparam int HOLD_CYCLES  = 60;      // length of the long output hold-off
    localparam int DRAIN_CYCLES = 10;      // quiet cycles after the last result

    // what an input word asks of the block
    typedef enum logic {
        ACT_RECEIVE = 1'b0,
        ACT_READ    = 1'b1
    } word_action_t;

    // parser phases of the local deframer model
    typedef enum logic [7:0] {
        SEEK_HDR1   = 8'b0000_0001,
        SEEK_HDR2   = 8'b0000_0010,
        GET_CMD     = 8'b0000_0100,
        GET_LEN_HI  = 8'b0000_1000,
        GET_LEN_LO  = 8'b0001_0000,
        GET_PAYLOAD = 8'b0010_0000,
        GET_CRC     = 8'b0100_0000,
        GET_TAIL    = 8'b1000_0000
    } deframe_phase_t;

    // ways a generated frame can be broken
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_TAIL,
        FRAME_BAD_CRC,
        FRAME_BAD_HDR2,
        FRAME_OVERSIZE,
        FRAME_CUT
    } frame_fault_t;

    typedef struct packed {
        word_action_t act;
        logic [7:0]   rx;
        logic [7:0]   idx;
    } in_word_t;

    typedef struct packed {
        logic       pkt;
        logic [7:0] cmd;
        logic [8:0] len;
        logic [7:0] data;
    } result_t;

    // dut ports, all inputs known from time zero
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       action = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic [7:0] read_index = 8'h00;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = fprx_pkg::CFG_FIRST_HEADER;
    logic [8:0] cfg_data = 9'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       packet_valid;
    logic [7:0] cmd_out;
    logic [8:0] length_out;
    logic [7:0] read_data;

    // register copies, reset values of the block
    logic [7:0] hdr1_val = 8'd170;
    logic [7:0] hdr2_val = 8'd85;
    logic [7:0] tail_val = 8'd187;
    logic [8:0] limit_val = 9'd256;

    // deframer model state
    deframe_phase_t dphase = SEEK_HDR1;
    logic [7:0]     fr_cmd = 8'h00;
    logic [15:0]    fr_len = 16'h0000;
    logic [8:0]     fr_count = 9'd0;
    logic [1:0]     crc_idx = 2'd0;
    logic [31:0]    crc_rcvd = 32'h0;
    logic [31:0]    crc_run = 32'hFFFF_FFFF;
    logic [7:0]     bank_mem [0:2*PAYLOAD_MAX-1];
    logic           live_bank = 1'b0;
    logic [7:0]     live_cmd = 8'h00;
    logic [8:0]     live_len = 9'd0;

    // words waiting to be sent and results owed by the block
    in_word_t tx_words [$];
    result_t  owed_results [$];
    in_word_t cur_word = '0;
    logic     word_held = 1'b0;
    int       burst_left = 0;
    int       gap_left = 0;

    // receiver stall pattern and long hold-off requests
    int   holds_asked = 0;
    int   holds_done = 0;
    int   hold_left = 0;
    int   pattern_left = 0;
    logic pattern_stall = 1'b0;

    // bookkeeping
    logic mix_reads = 1'b0;
    int   words_queued = 0;
    int   words_sent = 0;
    int   words_checked = 0;
    int   reads_sent = 0;
    int   frames_built = 0;
    int   frames_delivered = 0;
    int   longest_frame = 0;
    int   settings_used = 1;
    int   errors = 0;

    framed_packet_receiver_crc32_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .rx_byte      (rx_byte),
        .read_index   (read_index),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .packet_valid (packet_valid),
        .cmd_out      (cmd_out),
        .length_out   (length_out),
        .read_data    (read_data)
    );

    // 10 time unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        foreach (bank_mem[k])
            bank_mem[k] = 8'h00;
    end

    // reflected crc-32, lsb first, one byte
    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        repeat (8)
            c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
        return c;
    endfunction

    // advance the deframer model by one accepted word and give its result
    function automatic result_t deframe_word(input in_word_t w);
        result_t r;
        int      cap;
        r = '0;
        if (w.act == ACT_RECEIVE)
        begin
            unique case (dphase)
                SEEK_HDR1:
                    if (w.rx == hdr1_val)
                        dphase = SEEK_HDR2;
                // a wrong second header is dropped, not retried as a first header
                SEEK_HDR2:
                    dphase = (w.rx == hdr2_val) ? GET_CMD : SEEK_HDR1;
                GET_CMD:
                begin
                    fr_cmd = w.rx;
                    dphase = GET_LEN_HI;
                end
                GET_LEN_HI:
                begin
                    fr_len = {w.rx, 8'h00};
                    dphase = GET_LEN_LO;
                end
                GET_LEN_LO:
                begin
                    fr_len = {fr_len[15:8], w.rx};
                    cap = (limit_val > PAYLOAD_MAX) ? PAYLOAD_MAX : limit_val;
                    if (fr_len > cap)
                        dphase = SEEK_HDR1;
                    else
                    begin
                        // crc state restarts for every accepted length, zero too
                        fr_count = 9'd0;
                        crc_idx = 2'd0;
                        crc_run = 32'hFFFF_FFFF;
                        dphase = (fr_len > 0) ? GET_PAYLOAD : GET_CRC;
                    end
                end
                GET_PAYLOAD:
                begin
                    // the frame in progress fills the bank not being read
                    if (fr_count < PAYLOAD_MAX)
                        bank_mem[{~live_bank, fr_count[7:0]}] = w.rx;
                    crc_run = crc32_step(crc_run, w.rx);
                    fr_count = fr_count + 9'd1;
                    if (fr_count >= fr_len)
                    begin
                        crc_idx = 2'd0;
                        dphase = GET_CRC;
                    end
                end
                GET_CRC:
                begin
                    crc_rcvd = {crc_rcvd[23:0], w.rx};
                    if (crc_idx == 2'd3)
                    begin
                        crc_idx = 2'd0;
                        dphase = GET_TAIL;
                    end
                    else
                        crc_idx = crc_idx + 2'd1;
                end
                GET_TAIL:
                begin
                    dphase = SEEK_HDR1;
                    if (w.rx == tail_val && ~crc_run == crc_rcvd)
                    begin
                        live_bank = ~live_bank;
                        live_cmd = fr_cmd;
                        live_len = fr_len[8:0];
                        r.pkt = 1'b1;
                    end
                end
                default:
                    dphase = SEEK_HDR1;
            endcase
        end
        else if (w.idx < live_len)
            r.data = bank_mem[{live_bank, w.idx}];
        r.cmd = live_cmd;
        r.len = live_len;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch on %s at result %0d: got %0h, want %0h",
                 what, words_checked, got, want);
    endtask

    // driver: bursts of words with random gaps, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin : word_driver
        logic take;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= ACT_RECEIVE;
            rx_byte <= 8'h00;
            read_index <= 8'h00;
            word_held = 1'b0;
        end
        else
        begin
            take = in_valid && !in_stall;
            if (take)
            begin
                // expectation goes in before the word is released
                owed_results.push_back(deframe_word(cur_word));
                words_sent++;
                if (cur_word.act == ACT_READ)
                    reads_sent++;
                word_held = 1'b0;
            end
            if (!word_held)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (tx_words.size() > 0)
                begin
                    cur_word = tx_words.pop_front();
                    word_held = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            in_valid <= word_held;
            action <= cur_word.act;
            rx_byte <= cur_word.rx;
            read_index <= cur_word.idx;
        end
    end

    // receiver: stall runs and free runs of random length, plus long hold-offs
    always @(posedge clk or negedge rst_n)
    begin : stall_gen
        logic stall_now;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (hold_left == 0 && holds_done < holds_asked)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_now = 1'b1;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_stall = ($urandom_range(0, 9) < 3);
                    if (pattern_stall)
                        pattern_left = $urandom_range(1, 5);
                    else
                        pattern_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                                    : $urandom_range(1, 8);
                end
                pattern_left--;
                stall_now = pattern_stall;
            end
            out_stall <= stall_now;
        end
    end

    // monitor: every accepted result against the oldest owed one
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_results.size() == 0)
                report_mismatch("unexpected result word", 32'(packet_valid), 32'd0);
            else
            begin
                want = owed_results.pop_front();
                if (packet_valid !== want.pkt)
                    report_mismatch("packet_valid", 32'(packet_valid), 32'(want.pkt));
                if (cmd_out !== want.cmd)
                    report_mismatch("cmd_out", 32'(cmd_out), 32'(want.cmd));
                if (length_out !== want.len)
                    report_mismatch("length_out", 32'(length_out), 32'(want.len));
                if (read_data !== want.data)
                    report_mismatch("read_data", 32'(read_data), 32'(want.data));
                if (want.pkt)
                begin
                    frames_delivered++;
                    if (want.len > longest_frame)
                        longest_frame = int'(want.len);
                end
                words_checked++;
            end
        end
    end

    task automatic queue_word(input word_action_t act, input logic [7:0] b,
                              input logic [7:0] idx);
        in_word_t w;
        w.act = act;
        w.rx = b;
        w.idx = idx;
        tx_words.push_back(w);
        words_queued++;
    endtask

    // one received byte, now and then preceded by a read of the delivered payload
    task automatic queue_rx(input logic [7:0] b);
        if (mix_reads && $urandom_range(0, 99) < 12)
            queue_word(ACT_READ, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                               : $urandom_range(0, 255)));
        queue_word(ACT_RECEIVE, b, 8'($urandom_range(0, 255)));
    endtask

    // build one frame under the current register copies, possibly broken
    task automatic send_frame(input frame_fault_t fault, input int len);
        logic [7:0]  seq [$];
        logic [7:0]  b;
        logic [31:0] crc;
        logic [15:0] len_field;
        int          cap;
        int          n;
        cap = (limit_val > PAYLOAD_MAX) ? PAYLOAD_MAX : limit_val;
        len_field = len[15:0];
        if (fault == FRAME_OVERSIZE)
            len_field = 16'($urandom_range(0, 1) ? cap + 1 + $urandom_range(0, 3)
                                                 : $urandom_range(cap + 1, 65535));
        seq.push_back(hdr1_val);
        if (fault == FRAME_BAD_HDR2)
            seq.push_back(hdr2_val ^ 8'($urandom_range(1, 255)));
        else
        begin
            seq.push_back(hdr2_val);
            seq.push_back(8'($urandom_range(0, 255)));
            seq.push_back(len_field[15:8]);
            seq.push_back(len_field[7:0]);
            if (fault != FRAME_OVERSIZE)
            begin
                crc = 32'hFFFF_FFFF;
                for (n = 0; n < len; n++)
                begin
                    b = 8'($urandom_range(0, 255));
                    seq.push_back(b);
                    crc = crc32_step(crc, b);
                end
                crc = ~crc;
                if (fault == FRAME_BAD_CRC)
                    crc = crc ^ (32'h1 << $urandom_range(0, 31));
                for (n = 3; n >= 0; n--)
                    seq.push_back(crc[8*n +: 8]);
                seq.push_back((fault == FRAME_BAD_TAIL) ? tail_val ^ 8'($urandom_range(1, 255))
                                                        : tail_val);
                // truncated frame, the parser resyncs on whatever follows
                if (fault == FRAME_CUT)
                begin
                    n = $urandom_range(3, seq.size() - 1);
                    while (seq.size() > n)
                        void'(seq.pop_back());
                end
            end
        end
        foreach (seq[k])
            queue_rx(seq[k]);
        frames_built++;
    endtask

    // mostly well-formed frames with random content, some noise and broken frames
    task automatic random_traffic(input int budget);
        frame_fault_t fault;
        int           stop_at;
        int           cap;
        int           pick;
        stop_at = words_queued + budget;
        cap = (limit_val > PAYLOAD_MAX) ? PAYLOAD_MAX : limit_val;
        while (words_queued < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                repeat ($urandom_range(1, 3))
                    queue_rx(8'($urandom_range(0, 255)));
            else
            begin
                pick = $urandom_range(0, 99);
                fault = (pick < 60) ? FRAME_GOOD :
                        (pick < 68) ? FRAME_BAD_TAIL :
                        (pick < 78) ? FRAME_BAD_CRC :
                        (pick < 86) ? FRAME_BAD_HDR2 :
                        (pick < 94) ? FRAME_OVERSIZE : FRAME_CUT;
                send_frame(fault, ($urandom_range(0, 9) < 7)
                                  ? $urandom_range(0, (cap < 8) ? cap : 8)
                                  : $urandom_range(0, (cap < 40) ? cap : 40));
            end
        end
    endtask

    // nothing queued, nothing offered and nothing owed
    task automatic wait_idle();
        @(negedge clk);
        while (tx_words.size() != 0 || word_held || owed_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input fprx_pkg::cfg_idx_t idx, input logic [8:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            fprx_pkg::CFG_FIRST_HEADER:  hdr1_val = val[7:0];
            fprx_pkg::CFG_SECOND_HEADER: hdr2_val = val[7:0];
            fprx_pkg::CFG_TAIL_MARKER:   tail_val = val[7:0];
            fprx_pkg::CFG_LENGTH_LIMIT:  limit_val = val;
            default: ;
        endcase
    endtask

    // new register setting, only once the block has gone quiet
    task automatic set_registers(input logic [7:0] h1, input logic [7:0] h2,
                                 input logic [7:0] tl, input logic [8:0] lim);
        wait_idle();
        write_reg(fprx_pkg::CFG_FIRST_HEADER, {1'b0, h1});
        write_reg(fprx_pkg::CFG_SECOND_HEADER, {1'b0, h2});
        write_reg(fprx_pkg::CFG_TAIL_MARKER, {1'b0, tl});
        write_reg(fprx_pkg::CFG_LENGTH_LIMIT, lim);
        settings_used++;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] shared_hdr;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words under the reset registers, no interleaved reads
        send_frame(FRAME_GOOD, 1);
        queue_word(ACT_READ, 8'h00, 8'd0);
        queue_word(ACT_READ, 8'hFF, 8'd255);   // past the delivered length
        send_frame(FRAME_BAD_HDR2, 0);
        send_frame(FRAME_OVERSIZE, 0);
        send_frame(FRAME_BAD_CRC, 0);          // zero length, straight to the crc bytes

        // largest payload once, parser is back at the header search here
        send_frame(FRAME_GOOD, PAYLOAD_MAX);
        queue_word(ACT_READ, 8'($urandom_range(0, 255)), 8'd255);
        queue_word(ACT_READ, 8'($urandom_range(0, 255)), 8'd0);
        mix_reads = 1'b1;
        random_traffic(20);

        // zero limit: only empty frames get through
        set_registers(8'h00, 8'hFF, 8'h00, 9'd0);
        random_traffic(20);

        // opposite extremes, with a long hold-off on the result side
        set_registers(8'hFF, 8'h00, 8'hFF, 9'd256);
        random_traffic(25);
        holds_asked++;

        // random markers; the sender pauses midway until all results are back
        set_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 9'($urandom_range(1, 255)));
        random_traffic(10);
        wait_idle();
        random_traffic(10);

        // both headers the same value
        shared_hdr = 8'($urandom_range(0, 255));
        set_registers(shared_hdr, shared_hdr, 8'($urandom_range(0, 255)), 9'd16);
        random_traffic(20);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d words (%0d reads) in %0d frames over %0d register settings",
                 words_sent, reads_sent, frames_built, settings_used);
        $display("%0d results checked, %0d frames delivered, longest payload %0d bytes",
                 words_checked, frames_delivered, longest_frame);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin : watchdog
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/fprx_pkg.sv
rtl/core/fprx_parser.sv
rtl/core/fprx_store.sv
rtl/core/framed_packet_receiver_crc32_top.sv
verif/tb_framed_packet_receiver_crc32_top.sv
